### hw/rtl/almost_prime_classifier_unit_assert.svh
// Assertion macros used by the classifier checker.
`ifndef ALMOST_PRIME_CLASSIFIER_UNIT_ASSERT_SVH
`define ALMOST_PRIME_CLASSIFIER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/apc_pkg.sv
// Shared constants and types of the almost-prime classifier.
package apc_pkg;

    localparam int VALUE_BITS = 20;
    localparam int COUNT_BITS = 4;
    localparam int STEP_BITS  = $clog2(VALUE_BITS + 1);
    localparam int PROD_BITS  = VALUE_BITS + 7;

    localparam logic [COUNT_BITS-1:0] CAP_RESET = COUNT_BITS'(5);
    localparam logic [COUNT_BITS-1:0] CAP_MIN   = COUNT_BITS'(2);
    localparam logic [COUNT_BITS-1:0] CAP_MAX   = COUNT_BITS'(14);
    localparam logic [COUNT_BITS-1:0] SEMI_COUNT = COUNT_BITS'(2);
    localparam logic [PROD_BITS-1:0]  CLOSE_SCALE = PROD_BITS'(100);

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [VALUE_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [VALUE_BITS-1:0] remainder;
    } t_div_rsp;

endpackage

### hw/rtl/almost_prime_classifier_unit.sv
// Top level of the almost-prime classifier: trial-division sequencer and result register.
//
// A number is taken when start is high and busy is low. The block factors it
// by trial division (2, then 3, 5, 7, ...) with one shared bit-serial divider,
// whose quotient also serves as the square-root test, since d*d > x exactly
// when d > x/d. The result appears on the output ports with o_done high for
// exactly one cycle; the receiver must take it then. busy falls in the same
// cycle, so the next transfer may start at once. max_factors is written
// through i_cfg_we/i_cfg_wdata; the user must do so only while the block is
// idle, as the block itself does not enforce this; values below 2 act as 2
// and 15 acts as 14.
module almost_prime_classifier_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [apc_pkg::COUNT_BITS-1:0]  i_cfg_wdata,
    input  logic                            start,
    output logic                            busy,
    input  logic [apc_pkg::VALUE_BITS-1:0]  i_number,
    output logic                            o_done,
    output logic [apc_pkg::COUNT_BITS-1:0]  o_factor_count,
    output logic                            o_count_saturated,
    output logic                            o_almost_prime_flag,
    output logic                            o_semiprime_flag,
    output logic [apc_pkg::VALUE_BITS-1:0]  o_smaller_factor,
    output logic [apc_pkg::VALUE_BITS-1:0]  o_larger_factor,
    output logic                            o_close_pair_flag
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } t_state;

    t_state                          r_state;
    logic [apc_pkg::COUNT_BITS-1:0]  r_max_factors;
    logic [apc_pkg::VALUE_BITS-1:0]  r_x;
    logic [apc_pkg::VALUE_BITS-1:0]  r_d;
    logic [apc_pkg::COUNT_BITS-1:0]  r_count;
    logic [apc_pkg::VALUE_BITS-1:0]  r_first;
    logic [apc_pkg::VALUE_BITS-1:0]  r_second;
    logic                            r_div_start;

    apc_pkg::t_div_req div_req;
    apc_pkg::t_div_rsp div_rsp;

    logic [apc_pkg::COUNT_BITS-1:0]  kmax;
    logic [apc_pkg::COUNT_BITS-1:0]  limit;
    logic                            keep_going;
    logic                            is_semi;
    logic [apc_pkg::VALUE_BITS-1:0]  factor_gap;
    logic [apc_pkg::PROD_BITS-1:0]   scaled_gap;
    logic [apc_pkg::VALUE_BITS-1:0]  found;
    logic                            got_factor;

    assign kmax = (r_max_factors < apc_pkg::CAP_MIN) ? apc_pkg::CAP_MIN :
                  (r_max_factors > apc_pkg::CAP_MAX) ? apc_pkg::CAP_MAX : r_max_factors;
    assign limit = kmax + 1'b1;

    assign keep_going = (r_x > apc_pkg::VALUE_BITS'(1)) && (r_count < limit);

    // Quotient below the divisor means the remaining cofactor is prime.
    assign got_factor = (div_rsp.quotient < r_d) || (div_rsp.remainder == '0);
    assign found      = (div_rsp.quotient < r_d) ? r_x : r_d;

    // Factors arrive in ascending order, so the second is never the smaller.
    // gap <= floor(larger/100) is the same as 100*gap <= larger.
    assign is_semi    = (r_count == apc_pkg::SEMI_COUNT);
    assign factor_gap = r_second - r_first;
    assign scaled_gap = apc_pkg::PROD_BITS'(factor_gap) * apc_pkg::CLOSE_SCALE;

    assign div_req.start    = r_div_start;
    assign div_req.dividend = r_x;
    assign div_req.divisor  = r_d;

    apc_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_factors <= apc_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_max_factors <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_start <= 1'b0;
            o_done      <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            o_done      <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_x      <= i_number;
                        r_d      <= apc_pkg::VALUE_BITS'(2);
                        r_count  <= '0;
                        r_first  <= '0;
                        r_second <= '0;
                        r_state  <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (keep_going) begin
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV;
                    end else begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        if (got_factor) begin
                            if (r_count == '0) begin
                                r_first <= found;
                            end
                            if (r_count == apc_pkg::COUNT_BITS'(1)) begin
                                r_second <= found;
                            end
                            r_count <= r_count + 1'b1;
                            r_x     <= (div_rsp.quotient < r_d) ?
                                       apc_pkg::VALUE_BITS'(1) : div_rsp.quotient;
                        end else begin
                            r_d <= (r_d == apc_pkg::VALUE_BITS'(2)) ?
                                   apc_pkg::VALUE_BITS'(3) : r_d + apc_pkg::VALUE_BITS'(2);
                        end
                        r_state <= ST_CHECK;
                    end
                end
                ST_FINISH: begin
                    o_done              <= 1'b1;
                    o_factor_count      <= r_count;
                    o_count_saturated   <= (r_count >= limit);
                    o_almost_prime_flag <= (r_count >= apc_pkg::SEMI_COUNT) && (r_count <= kmax);
                    o_semiprime_flag    <= is_semi;
                    o_smaller_factor    <= is_semi ? r_first : '0;
                    o_larger_factor     <= is_semi ? r_second : '0;
                    o_close_pair_flag   <= is_semi && (r_second > r_first) &&
                                           (scaled_gap <= apc_pkg::PROD_BITS'(r_second));
                    r_state             <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = (r_state != ST_IDLE);

endmodule

### hw/rtl/apc_divider.sv
// Radix-2 restoring divider: one quotient bit per cycle.
module apc_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  apc_pkg::t_div_req i_req,
    output apc_pkg::t_div_rsp o_rsp
);

    logic [apc_pkg::VALUE_BITS:0]   r_rem;
    logic [apc_pkg::VALUE_BITS-1:0] r_quo;
    logic [apc_pkg::VALUE_BITS-1:0] r_dvsr;
    logic [apc_pkg::STEP_BITS-1:0]  r_steps;
    logic                           r_busy;
    logic                           r_done;

    logic [apc_pkg::VALUE_BITS:0] shifted;
    logic [apc_pkg::VALUE_BITS:0] trial;

    assign shifted = {r_rem[apc_pkg::VALUE_BITS-1:0], r_quo[apc_pkg::VALUE_BITS-1]};
    assign trial   = shifted - {1'b0, r_dvsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_steps <= apc_pkg::STEP_BITS'(apc_pkg::VALUE_BITS);
            end else if (r_busy) begin
                r_steps <= r_steps - 1'b1;
                if (r_steps == apc_pkg::STEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quo  <= i_req.dividend;
            r_dvsr <= i_req.divisor;
        end else if (r_busy) begin
            // A clear sign bit means the divisor fits into the partial remainder.
            if (!trial[apc_pkg::VALUE_BITS]) begin
                r_rem <= trial;
            end else begin
                r_rem <= shifted;
            end
            r_quo <= {r_quo[apc_pkg::VALUE_BITS-2:0], ~trial[apc_pkg::VALUE_BITS]};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem[apc_pkg::VALUE_BITS-1:0];

endmodule

### hw/rtl/apc_checker.sv
// Port-level checker for the almost-prime classifier, bound to the top level.
`include "almost_prime_classifier_unit_assert.svh"

module apc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            o_done,
    input logic [apc_pkg::COUNT_BITS-1:0]  o_factor_count,
    input logic                            o_count_saturated,
    input logic                            o_almost_prime_flag,
    input logic                            o_semiprime_flag,
    input logic [apc_pkg::VALUE_BITS-1:0]  o_smaller_factor,
    input logic [apc_pkg::VALUE_BITS-1:0]  o_larger_factor,
    input logic                            o_close_pair_flag
);

    // An accepted number keeps the block busy until its result is out.
    `APC_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy, "busy did not rise after a transfer")
    `APC_ASSERT_SAME(a_idle_with_result, i_clk, i_rst_n, o_done, !busy, "result shown while still busy")
    `APC_ASSERT_SAME(a_semi_count, i_clk, i_rst_n, o_done && o_semiprime_flag, o_factor_count == apc_pkg::SEMI_COUNT && o_almost_prime_flag, "semiprime without a count of two")
    `APC_ASSERT_SAME(a_close_pair, i_clk, i_rst_n, o_done && o_close_pair_flag, o_semiprime_flag && (o_smaller_factor < o_larger_factor), "close pair on a non-semiprime or square")
    `APC_ASSERT_SAME(a_sat_not_almost, i_clk, i_rst_n, o_done && o_count_saturated, !o_almost_prime_flag && !o_semiprime_flag, "saturated count flagged as almost prime")

endmodule

bind almost_prime_classifier_unit apc_checker u_apc_checker (.*);
